// File: design/pms_pkg.sv
// Shared types and codes for the predecessor-or-maximum search block.
`default_nettype none

package pms_pkg;

	// Request kinds carried on the kind port.
	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_RESULT
	} state_t;

	// Controls from the sequencer to the compare unit.
	typedef struct packed {
		logic init;  // forget earlier candidates at query start
		logic en;    // one entry is on the compare inputs
	} pms_ctl_t;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned IDX_W = 9;

endpackage

`default_nettype wire

// File: design/predecessor_or_max_search.sv
// Top level: ordered value store with predecessor-or-maximum search.
`default_nettype none

// Usage:
//   Requests enter on start/kind/value/last_query and are taken at a rising
//   edge with start high and busy low. Kind clear empties the store, kind
//   append writes value at the end (dropped when DEPTH entries are held);
//   both finish in the accepting cycle, give no result and leave busy low.
//   Kind query returns one result: done is high for exactly one cycle with
//   found, target_index, target_value and last valid. The result is the
//   largest entry strictly below the query value, or the earliest maximum
//   when none lies below; ties go to the earliest position.
//   A query over n entries reads the single memory port once per entry in
//   the scan state, then passes a tail state and the result state, where
//   done is high; busy stays high through it. A query on an empty store
//   goes straight to the result state. The receiver cannot stall; the
//   result is shown once and must be captured in its done cycle.
//   Reset (arst_n low) empties the store and returns to idle; memory
//   contents need no clearing since only filled positions are read.
module predecessor_or_max_search #(
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic        [1:0]                kind,
	input  wire logic signed [pms_pkg::VAL_W-1:0] value,
	input  wire logic                             last_query,
	output logic                                  done,
	output logic                                  found,
	output logic             [pms_pkg::IDX_W-1:0] target_index,
	output logic signed      [pms_pkg::VAL_W-1:0] target_value,
	output logic                                  last
);
	import pms_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (AW > IDX_W) ? AW : IDX_W;

	state_t                  state_q;
	state_t                  state_d;
	logic                    accept;
	logic                    is_query;
	logic                    clr;
	logic                    app;
	logic                    scan_last;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           rd_q;
	logic [AW-1:0]           idx_s1;
	logic                    vld_s1;
	logic signed [VAL_W-1:0] rdata_s1;
	logic signed [VAL_W-1:0] query_q;
	logic                    found_q;
	logic                    last_q;
	logic [AW-1:0]           sel_pos;
	logic signed [VAL_W-1:0] sel_val;
	logic [PW-1:0]           pos_ext;
	pms_ctl_t                ctl;

	// Busy is low only in idle, so take requests straight from the state.
	assign accept    = start && (state_q == ST_IDLE);
	assign is_query  = (kind == KIND_QUERY);
	assign scan_last = ((CW'(rd_q) + CW'(1)) == count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					state_d = (count_q == '0) ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL:   state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		clr      = 1'b0;
		app      = 1'b0;
		ctl.init = 1'b0;
		ctl.en   = vld_s1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					case (kind_t'(kind))
						KIND_CLEAR:  clr      = 1'b1;
						KIND_APPEND: app      = 1'b1;
						KIND_QUERY:  ctl.init = 1'b1;
						default:     clr      = 1'b0;
					endcase
				end
			end
			ST_SCAN:   busy = 1'b1;
			ST_TAIL:   busy = 1'b1;
			ST_RESULT: done = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			rd_q    <= '0;
		end else begin
			state_q <= state_d;
			// Issue one read per scan cycle; its data comes back registered, in step with vld_s1.
			vld_s1  <= (state_q == ST_SCAN);
			if (ctl.init) begin
				rd_q <= '0;
			end else if (state_q == ST_SCAN) begin
				rd_q <= rd_q + AW'(1);
			end
		end
	end

	// Hold the query operands and the read position for the compare stage.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q;
		if (ctl.init) begin
			query_q <= value;
			found_q <= (count_q != '0);
			last_q  <= last_query;
		end
	end

	pms_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.app      (app),
		.wdata    (value),
		.raddr    (rd_q),
		.rdata_s1 (rdata_s1),
		.count_q  (count_q)
	);

	pms_track #(
		.AW (AW)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.entry   (rdata_s1),
		.idx     (idx_s1),
		.query   (query_q),
		.sel_pos (sel_pos),
		.sel_val (sel_val)
	);

	// Drop upper position bits beyond the index port; zero the payload when empty.
	assign pos_ext      = PW'(sel_pos);
	assign found        = found_q;
	assign target_index = found_q ? pos_ext[IDX_W-1:0] : '0;
	assign target_value = found_q ? sel_val : '0;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy query");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && is_query) |=> busy)
		else $error("accepted query did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block not idle after result");

	a_no_cmp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !vld_s1)
		else $error("compare stage active while idle");
`endif

endmodule

`default_nettype wire

// File: design/pms_store.sv
// Entry memory with fill count, one write port and one registered read port.
`default_nettype none

module pms_store #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9,
	parameter int unsigned CW    = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            clr,
	input  wire logic                            app,
	input  wire logic signed [pms_pkg::VAL_W-1:0] wdata,
	input  wire logic        [AW-1:0]            raddr,
	output logic signed      [pms_pkg::VAL_W-1:0] rdata_s1,
	output logic             [CW-1:0]            count_q
);
	import pms_pkg::*;

	logic signed [VAL_W-1:0] mem_q [0:DEPTH-1];
	logic                    full;

	assign full = (count_q == CW'(DEPTH));

	// Fill count: clear empties, append advances unless full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (app && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (app && !full) begin
			mem_q[count_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/pms_track.sv
// Shared compare unit: tracks the running maximum and the best predecessor.
`default_nettype none

module pms_track #(
	parameter int unsigned AW = 9
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pms_pkg::pms_ctl_t                ctl,
	input  wire logic signed [pms_pkg::VAL_W-1:0] entry,
	input  wire logic        [AW-1:0]             idx,
	input  wire logic signed [pms_pkg::VAL_W-1:0] query,
	output logic             [AW-1:0]             sel_pos,
	output logic signed      [pms_pkg::VAL_W-1:0] sel_val
);
	import pms_pkg::*;

	logic                    have_max_q;
	logic                    pred_ok_q;
	logic signed [VAL_W-1:0] max_val_q;
	logic signed [VAL_W-1:0] pred_val_q;
	logic        [AW-1:0]    max_pos_q;
	logic        [AW-1:0]    pred_pos_q;
	logic                    take_max;
	logic                    take_pred;

	// Strict compares keep the earliest position on ties.
	assign take_max  = ctl.en && (!have_max_q || (entry > max_val_q));
	assign take_pred = ctl.en && (entry < query) && (!pred_ok_q || (entry > pred_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_max_q <= 1'b0;
			pred_ok_q  <= 1'b0;
		end else if (ctl.init) begin
			have_max_q <= 1'b0;
			pred_ok_q  <= 1'b0;
		end else begin
			if (take_max) begin
				have_max_q <= 1'b1;
			end
			if (take_pred) begin
				pred_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_max) begin
			max_val_q <= entry;
			max_pos_q <= idx;
		end
		if (take_pred) begin
			pred_val_q <= entry;
			pred_pos_q <= idx;
		end
	end

	// Fall back to the maximum when nothing lies below the query.
	assign sel_pos = pred_ok_q ? pred_pos_q : max_pos_q;
	assign sel_val = pred_ok_q ? pred_val_q : max_val_q;

endmodule

`default_nettype wire

// File: verif/pms_checker.sv
// Result checker for the predecessor-or-maximum search block.
`default_nettype none

module pms_checker #(
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             busy,
	input  wire logic        [1:0]                kind,
	input  wire logic signed [pms_pkg::VAL_W-1:0] value,
	input  wire logic                             last_query,
	input  wire logic                             done,
	input  wire logic                             found,
	input  wire logic        [pms_pkg::IDX_W-1:0] target_index,
	input  wire logic        [pms_pkg::VAL_W-1:0] target_value,
	input  wire logic                             last,
	output int                                    errors,
	output int                                    pending
);
	import pms_pkg::*;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   index;
		logic [VAL_W-1:0]   val;
		logic               last;
	} answer_t;

	logic signed [VAL_W-1:0] store_vals [DEPTH];
	int unsigned             store_count;
	answer_t                 answers [$];

	initial begin
		errors = 0;
		pending = 0;
		store_count = 0;
	end

	task automatic report_mismatch(input string field, input longint want, input longint got);
		$display("[%0t] %s mismatch: want %0d, got %0d", $time, field, want, got);
		errors++;
	endtask

	// Largest entry strictly below the probe, else the earliest maximum.
	function automatic answer_t search_store(input logic signed [VAL_W-1:0] probe,
			input logic lq);
		answer_t                 res;
		int unsigned             top_pos;
		int unsigned             below_pos;
		int unsigned             pos;
		logic signed [VAL_W-1:0] top_val;
		logic signed [VAL_W-1:0] below_val;
		logic signed [VAL_W-1:0] e;
		logic                    have_below;
		res = '0;
		res.last = lq;
		top_pos = 0;
		below_pos = 0;
		top_val = '0;
		below_val = '0;
		have_below = 1'b0;
		if (store_count == 0)
			return res;
		for (int unsigned i = 0; i < store_count; i++) begin
			e = store_vals[i];
			if (i == 0 || e > top_val) begin
				top_val = e;
				top_pos = i;
			end
			if (e < probe && (!have_below || e > below_val)) begin
				below_val = e;
				below_pos = i;
				have_below = 1'b1;
			end
		end
		pos = have_below ? below_pos : top_pos;
		res.found = 1'b1;
		res.index = IDX_W'(pos);
		res.val = store_vals[pos];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			store_count = 0;
			answers.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (answers.size() == 0) begin
					report_mismatch("result with nothing pending, found", 0, found);
				end else begin
					want = answers.pop_front();
					if (found !== want.found)
						report_mismatch("found", want.found, found);
					if (target_index !== want.index)
						report_mismatch("target_index", want.index, target_index);
					if (target_value !== want.val)
						report_mismatch("target_value", signed'(want.val),
							signed'(target_value));
					if (last !== want.last)
						report_mismatch("last", want.last, last);
				end
			end
			if (start && !busy) begin
				if (kind == KIND_CLEAR) begin
					store_count = 0;
				end else if (kind == KIND_APPEND) begin
					if (store_count < DEPTH) begin
						store_vals[store_count] = value;
						store_count++;
					end
				end else if (kind == KIND_QUERY) begin
					answers.push_back(search_store(value, last_query));
				end
			end
			pending = answers.size();
		end
	end

endmodule

`default_nettype wire

// File: verif/tb_predecessor_or_max_search.sv
// Testbench top: request stimulus and verdict for the predecessor-or-maximum search.
`default_nettype none

module tb_predecessor_or_max_search;
	import pms_pkg::*;

	localparam int unsigned DEPTH = 512;
	// The unused kind code; the block must ignore it.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Allow a long run of full-store queries several times over.
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              kind;
	logic signed [VAL_W-1:0] value;
	logic                    last_query;
	logic                    done;
	logic                    found;
	logic [IDX_W-1:0]        target_index;
	logic signed [VAL_W-1:0] target_value;
	logic                    last;

	int                      errors;
	int                      pending;
	int unsigned             cycles = 0;

	// Stimulus bookkeeping only: how full the store is and what it holds,
	// so that query values can be aimed at stored entries.
	int unsigned             fill = 0;
	logic signed [VAL_W-1:0] held [$];
	int unsigned             items_sent = 0;
	int unsigned             idle_pct = 0;
	int unsigned             phase_idle [4] = '{0, 84, 25, 0};

	always #5 clk = ~clk;

	predecessor_or_max_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.last_query  (last_query),
		.done        (done),
		.found       (found),
		.target_index(target_index),
		.target_value(target_value),
		.last        (last)
	);

	pms_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.last_query  (last_query),
		.done        (done),
		.found       (found),
		.target_index(target_index),
		.target_value(target_value),
		.last        (last),
		.errors      (errors),
		.pending     (pending)
	);

	// Watchdog: end the run if the block hangs or a result never shows up.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Mix of extremes, small clustered values (for ties) and full-range noise.
	function automatic logic signed [VAL_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3, 4: return $urandom_range(0, 16) - 8;
			5:       return $urandom_range(0, 1) ? -1 : 0;
			default: return $urandom;
		endcase
	endfunction

	// Aim most queries at or next to a stored value, so that equal, just-below
	// and just-above probes all occur; the rest hit anywhere.
	function automatic logic signed [VAL_W-1:0] query_value();
		logic signed [VAL_W-1:0] base;
		if (held.size() != 0 && $urandom_range(0, 9) < 6) begin
			base = held[$urandom_range(0, held.size() - 1)];
			return base + ($urandom_range(0, 2) - 1);
		end
		return rand_value();
	endfunction

	// Send one request. Call at a falling edge; return at a falling edge.
	// Hold start and the fields until a rising edge sees busy low.
	task automatic send(input logic [1:0] k, input logic signed [VAL_W-1:0] v,
			input logic lq);
		// Idle the sender at random before the request goes out.
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			kind <= 2'($urandom);
			value <= $urandom;
			last_query <= 1'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		value <= v;
		last_query <= lq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Accepted at this edge; track what the store now holds.
		if (k == KIND_CLEAR) begin
			fill = 0;
			held.delete();
			items_sent++;
		end else if (k == KIND_APPEND) begin
			if (fill < DEPTH) begin
				fill++;
				held.push_back(v);
				items_sent++;
			end
		end else if (k == KIND_QUERY) begin
			items_sent++;
		end
		@(negedge clk);
	endtask

	initial begin
		logic signed [VAL_W-1:0] v;
		int unsigned             n;
		int unsigned             nq;
		int unsigned             goal;
		logic                    lq;

		// Drive every input from time zero; hold reset low at the start of the run.
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_CLEAR;
		value = '0;
		last_query = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: queries on an empty store must come back with found low.
		idle_pct = 0;
		send(KIND_QUERY, VAL_MAX, 1'b1);
		send(KIND_QUERY, VAL_MIN, 1'b0);

		// Extremes and repeated minimum and maximum to exercise tie-breaking.
		send(KIND_APPEND, VAL_MIN, 1'b0);
		send(KIND_APPEND, VAL_MAX, 1'b1);
		send(KIND_APPEND, 0, 1'b0);
		send(KIND_APPEND, -1, 1'b1);
		send(KIND_APPEND, 1, 1'b0);
		send(KIND_APPEND, VAL_MAX, 1'b0);
		send(KIND_APPEND, VAL_MIN, 1'b0);
		// Probe at the minimum: nothing below, so wrap to the earliest maximum.
		send(KIND_QUERY, VAL_MIN, 1'b0);
		// Probe above every non-maximum entry.
		send(KIND_QUERY, VAL_MAX, 1'b0);
		send(KIND_QUERY, 0, 1'b0);
		send(KIND_QUERY, 1, 1'b0);
		send(KIND_QUERY, -1, 1'b0);
		// Two copies of the minimum sit just below this probe: earliest wins.
		send(KIND_QUERY, VAL_MIN + 1, 1'b1);
		// Unused kind must be dropped without a result.
		send(KIND_UNUSED, 32'sh5a5a_a5a5, 1'b1);
		send(KIND_CLEAR, 0, 1'b0);
		send(KIND_QUERY, 7, 1'b1);
		// A single entry queried with its own value wraps to itself.
		send(KIND_APPEND, -5, 1'b0);
		send(KIND_QUERY, -5, 1'b1);

		// Fill the store to the last position, with the unique maximum at the
		// end so a wrapping query returns the top index; then overfill it.
		send(KIND_CLEAR, 0, 1'b0);
		repeat (DEPTH - 1) begin
			v = $urandom;
			if (v == VAL_MAX)
				v = 0;
			send(KIND_APPEND, v, 1'($urandom));
		end
		send(KIND_APPEND, VAL_MAX, 1'b0);
		send(KIND_APPEND, VAL_MIN, 1'b1);
		send(KIND_QUERY, VAL_MIN, 1'b1);
		send(KIND_QUERY, VAL_MAX, 1'b0);
		send(KIND_QUERY, 0, 1'b1);

		// Random batches: clear (usually), append a few values, then a run of
		// queries with last_query usually on the final one only.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			goal = items_sent + 45;
			while (items_sent < goal) begin
				if ($urandom_range(0, 9) < 7)
					send(KIND_CLEAR, rand_value(), 1'($urandom));
				n = $urandom_range(0, 12);
				repeat (n)
					send(KIND_APPEND, rand_value(), 1'($urandom));
				nq = $urandom_range(1, 6);
				for (int i = 0; i < nq; i++) begin
					lq = (i == nq - 1);
					if ($urandom_range(0, 9) == 0)
						lq = !lq;
					send(KIND_QUERY, query_value(), lq);
				end
				// Noise: any kind, including the unused one, at any point.
				if ($urandom_range(0, 9) == 0)
					send(2'($urandom_range(0, 3)), rand_value(), 1'($urandom));
			end
		end

		// Drop start, drain outstanding results, then let a full scan pass.
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
